@@ sv/fbpp_pkg.sv @@
// Shared types and constants for the FIFO page buffer pool with pinning.
`timescale 1ns / 1ps
`default_nettype none

package fbpp_pkg;

	// Fixed field widths
	localparam int PAGE_W     = 64;
	localparam int STATUS_W   = 3;
	localparam int POS_W      = 4;
	localparam int CNT_W      = 8;
	localparam int FRAMES_W   = 5;
	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 3;
	localparam int LIM_W      = 8;

	localparam logic [FRAMES_W-1:0] FRAMES_RESET = 5'd16;

	// Register index of frames_in_use (paddr[2])
	localparam logic REG_FRAMES = 1'b0;

	// Request codes
	localparam logic OP_FIX   = 1'b0;
	localparam logic OP_UNFIX = 1'b1;

	// Result status codes
	typedef enum logic [STATUS_W-1:0] {
		ST_HIT        = 3'd0,
		ST_LOADED     = 3'd1,
		ST_EVICTED    = 3'd2,
		ST_FULL       = 3'd3,
		ST_UNFIXED    = 3'd4,
		ST_UNFIX_MISS = 3'd5
	} status_t;

	// Sequencer states
	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_CHECK,
		S_DECIDE,
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_APPEND,
		S_DONE
	} state_t;

endpackage

`default_nettype wire

@@ sv/fifo_buffer_pool_pinning.sv @@
// FIFO page buffer pool with pin counts: queue memory, scan sequencer, APB register.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-----------------------------------------
//  in      | input     | in_valid / in_stall   | operation, page_id, mark_dirty
//  out     | output    | out_valid / out_stall | status, queue_position, pin_count,
//          |           |                       | evicted_page_id, write_back
//  apb     | input     | psel/penable/pready   | paddr, pwrite, pwdata, prdata
//
// One request at a time. The queue sits in a memory with one write port and one
// registered read port, scanned one entry at a time (read, then compare); an eviction
// moves each later entry up (read, then write), then appends the new page at the end.
// in_stall is high from acceptance until the result is loaded into the output register;
// a result waiting in that register does not block acceptance of the next request.
// Reset clears the occupancy count and sets frames_in_use to 16; no memory clearing.
`timescale 1ns / 1ps
`default_nettype none

module fifo_buffer_pool_pinning
	import fbpp_pkg::*;
#(
	parameter int MAX_FRAMES = 16,
	parameter int PIN_BITS   = 8
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,

	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic                  operation,
	input  wire logic [PAGE_W-1:0]     page_id,
	input  wire logic                  mark_dirty,

	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic [STATUS_W-1:0]        status,
	output logic [POS_W-1:0]           queue_position,
	output logic [CNT_W-1:0]           pin_count,
	output logic [PAGE_W-1:0]          evicted_page_id,
	output logic                       write_back,

	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [APB_ADDR_W-1:0] paddr,
	input  wire logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0]      prdata,
	output logic                       pready
);

	localparam int IDX_W   = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
	localparam int OCC_W   = $clog2(MAX_FRAMES + 1);
	localparam int ENTRY_W = PAGE_W + PIN_BITS + 1;

	localparam logic [PIN_BITS-1:0] PIN_MAX = {PIN_BITS{1'b1}};
	localparam logic [PIN_BITS-1:0] PIN_ONE = PIN_BITS'(1);
	localparam logic [OCC_W-1:0]    OCC_MAX = OCC_W'(MAX_FRAMES);

	// Control state
	state_t                state_q, state_d;
	logic [OCC_W-1:0]      occ_q;
	logic [OCC_W-1:0]      idx_q;
	logic [FRAMES_W-1:0]   frames_q;
	logic                  hit_q;
	logic                  victim_found_q;
	logic                  out_valid_q;

	// Request and scan payload
	logic                  op_q;
	logic [PAGE_W-1:0]     page_q;
	logic                  dirty_q;
	logic [OCC_W-1:0]      hit_idx_q;
	logic [PIN_BITS-1:0]   hit_pins_q;
	logic                  hit_dirty_q;
	logic [OCC_W-1:0]      victim_idx_q;
	logic [PAGE_W-1:0]     victim_page_q;
	logic                  victim_dirty_q;

	// Pending result
	status_t               res_status_q;
	logic [IDX_W-1:0]      res_pos_q;
	logic [PIN_BITS-1:0]   res_pins_q;
	logic [PAGE_W-1:0]     res_evict_q;
	logic                  res_wb_q;

	// Output register
	logic [STATUS_W-1:0]   status_q;
	logic [POS_W-1:0]      queue_position_q;
	logic [CNT_W-1:0]      pin_count_q;
	logic [PAGE_W-1:0]     evicted_page_id_q;
	logic                  write_back_q;

	// Queue memory
	logic [ENTRY_W-1:0]    mem_q [MAX_FRAMES];
	logic [ENTRY_W-1:0]    rd_data_q;
	logic [IDX_W-1:0]      rd_addr;
	logic                  wr_en;
	logic [IDX_W-1:0]      wr_addr;
	logic [ENTRY_W-1:0]    wr_data;

	// Derived values
	logic                  in_accept;
	logic                  out_free;
	logic                  cfg_write;
	logic [PAGE_W-1:0]     rd_page;
	logic [PIN_BITS-1:0]   rd_pins;
	logic                  rd_dirty;
	logic                  rd_match;
	logic [OCC_W-1:0]      idx_nxt;
	logic [OCC_W-1:0]      idx_nxt2;
	logic [OCC_W-1:0]      victim_nxt;
	logic [OCC_W-1:0]      occ_last;
	logic                  has_room;
	logic [PIN_BITS-1:0]   pins_inc;
	logic [PIN_BITS-1:0]   pins_dec;
	logic [IDX_W+POS_W-1:0]    pos_wide;
	logic [PIN_BITS+CNT_W-1:0] pins_wide;

	assign in_accept = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign cfg_write = psel && penable && pwrite && pready;

	assign rd_page  = rd_data_q[ENTRY_W-1 -: PAGE_W];
	assign rd_pins  = rd_data_q[PIN_BITS:1];
	assign rd_dirty = rd_data_q[0];
	assign rd_match = (rd_page == page_q);

	assign idx_nxt    = idx_q + OCC_W'(1);
	assign idx_nxt2   = idx_q + OCC_W'(2);
	assign victim_nxt = victim_idx_q + OCC_W'(1);
	assign occ_last   = occ_q - OCC_W'(1);

	// Room check against the frame limit (0 acts as 1, capped at MAX_FRAMES)
	assign has_room = (occ_q < OCC_MAX) &&
		((LIM_W'(occ_q) < LIM_W'(frames_q)) || ((frames_q == '0) && (occ_q == '0)));

	// Saturating pin count update
	assign pins_inc = (hit_pins_q == PIN_MAX) ? hit_pins_q : hit_pins_q + PIN_ONE;
	assign pins_dec = (hit_pins_q == '0) ? hit_pins_q : hit_pins_q - PIN_ONE;

	assign pos_wide  = {{POS_W{1'b0}}, res_pos_q};
	assign pins_wide = {{CNT_W{1'b0}}, res_pins_q};

	// Next state and memory port control
	always_comb begin
		state_d = state_q;
		rd_addr = idx_q[IDX_W-1:0];
		wr_en   = 1'b0;
		wr_addr = idx_q[IDX_W-1:0];
		wr_data = rd_data_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = (occ_q == '0) ? S_DECIDE : S_READ;
				end
			end
			S_READ: begin
				state_d = S_CHECK;
			end
			S_CHECK: begin
				if (rd_match || (idx_nxt >= occ_q)) begin
					state_d = S_DECIDE;
				end else begin
					state_d = S_READ;
				end
			end
			S_DECIDE: begin
				state_d = S_DONE;
				if (hit_q) begin
					wr_en   = 1'b1;
					wr_addr = hit_idx_q[IDX_W-1:0];
					if (op_q == OP_UNFIX) begin
						wr_data = {page_q, pins_dec, dirty_q};
					end else begin
						wr_data = {page_q, pins_inc, hit_dirty_q};
					end
				end else if (op_q == OP_FIX) begin
					if (has_room) begin
						wr_en   = 1'b1;
						wr_addr = occ_q[IDX_W-1:0];
						wr_data = {page_q, PIN_ONE, 1'b0};
					end else if (victim_found_q) begin
						state_d = (victim_nxt < occ_q) ? S_SHIFT_RD : S_APPEND;
					end
				end
			end
			S_SHIFT_RD: begin
				rd_addr = idx_nxt[IDX_W-1:0];
				state_d = S_SHIFT_WR;
			end
			S_SHIFT_WR: begin
				wr_en   = 1'b1;
				wr_addr = idx_q[IDX_W-1:0];
				wr_data = rd_data_q;
				state_d = (idx_nxt2 < occ_q) ? S_SHIFT_RD : S_APPEND;
			end
			S_APPEND: begin
				wr_en   = 1'b1;
				wr_addr = occ_last[IDX_W-1:0];
				wr_data = {page_q, PIN_ONE, 1'b0};
				state_d = S_DONE;
			end
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Queue memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	// Sequencer control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			occ_q          <= '0;
			idx_q          <= '0;
			frames_q       <= FRAMES_RESET;
			hit_q          <= 1'b0;
			victim_found_q <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_write && (paddr[2] == REG_FRAMES)) begin
				frames_q <= pwdata[FRAMES_W-1:0];
			end
			case (state_q)
				S_IDLE: begin
					if (in_accept) begin
						idx_q          <= '0;
						hit_q          <= 1'b0;
						victim_found_q <= 1'b0;
					end
				end
				S_CHECK: begin
					idx_q <= idx_nxt;
					if (rd_match) begin
						hit_q <= 1'b1;
					end else if (!victim_found_q && (rd_pins == '0)) begin
						victim_found_q <= 1'b1;
					end
				end
				S_DECIDE: begin
					idx_q <= victim_idx_q;
					if (!hit_q && (op_q == OP_FIX) && has_room) begin
						occ_q <= occ_q + OCC_W'(1);
					end
				end
				S_SHIFT_WR: begin
					idx_q <= idx_nxt;
				end
				default: begin
				end
			endcase
			// Output register handshake
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Request, scan and result payload
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_accept) begin
					op_q    <= operation;
					page_q  <= page_id;
					dirty_q <= mark_dirty;
				end
			end
			S_CHECK: begin
				if (rd_match) begin
					hit_idx_q   <= idx_q;
					hit_pins_q  <= rd_pins;
					hit_dirty_q <= rd_dirty;
				end else if (!victim_found_q && (rd_pins == '0)) begin
					victim_idx_q   <= idx_q;
					victim_page_q  <= rd_page;
					victim_dirty_q <= rd_dirty;
				end
			end
			S_DECIDE: begin
				res_status_q <= ST_FULL;
				res_pos_q    <= '0;
				res_pins_q   <= '0;
				res_evict_q  <= '0;
				res_wb_q     <= 1'b0;
				if (op_q == OP_UNFIX) begin
					if (hit_q) begin
						res_status_q <= ST_UNFIXED;
						res_pos_q    <= hit_idx_q[IDX_W-1:0];
						res_pins_q   <= pins_dec;
					end else begin
						res_status_q <= ST_UNFIX_MISS;
					end
				end else if (hit_q) begin
					res_status_q <= ST_HIT;
					res_pos_q    <= hit_idx_q[IDX_W-1:0];
					res_pins_q   <= pins_inc;
				end else if (has_room) begin
					res_status_q <= ST_LOADED;
					res_pos_q    <= occ_q[IDX_W-1:0];
					res_pins_q   <= PIN_ONE;
				end
			end
			S_APPEND: begin
				res_status_q <= ST_EVICTED;
				res_pos_q    <= occ_last[IDX_W-1:0];
				res_pins_q   <= PIN_ONE;
				res_evict_q  <= victim_page_q;
				res_wb_q     <= victim_dirty_q;
			end
			S_DONE: begin
				if (out_free) begin
					status_q          <= res_status_q;
					queue_position_q  <= pos_wide[POS_W-1:0];
					pin_count_q       <= pins_wide[CNT_W-1:0];
					evicted_page_id_q <= res_evict_q;
					write_back_q      <= res_wb_q;
				end
			end
			default: begin
			end
		endcase
	end

	// Ports
	assign in_stall        = (state_q != S_IDLE);
	assign out_valid       = out_valid_q;
	assign status          = status_q;
	assign queue_position  = queue_position_q;
	assign pin_count       = pin_count_q;
	assign evicted_page_id = evicted_page_id_q;
	assign write_back      = write_back_q;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_FRAMES) ?
		{{(APB_DATA_W - FRAMES_W){1'b0}}, frames_q} : '0;

endmodule

`default_nettype wire

@@ tb/fbpp_checker.sv @@
// Checker for the FIFO page buffer pool: tracks the pool state, predicts each result and compares.
`timescale 1ns / 1ps

module fbpp_checker
	import fbpp_pkg::*;
#(
	parameter int MAX_FRAMES = 16,
	parameter int PIN_BITS   = 8
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	input  wire logic                  in_stall,
	input  wire logic                  operation,
	input  wire logic [PAGE_W-1:0]     page_id,
	input  wire logic                  mark_dirty,
	input  wire logic                  out_valid,
	input  wire logic                  out_stall,
	input  wire logic [STATUS_W-1:0]   status,
	input  wire logic [POS_W-1:0]      queue_position,
	input  wire logic [CNT_W-1:0]      pin_count,
	input  wire logic [PAGE_W-1:0]     evicted_page_id,
	input  wire logic                  write_back,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic                  pready,
	input  wire logic [APB_ADDR_W-1:0] paddr,
	input  wire logic [APB_DATA_W-1:0] pwdata,
	output int                         fail_count,
	output int                         pending
);

	localparam logic [CNT_W-1:0] PIN_MAX = CNT_W'((1 << PIN_BITS) - 1);
	localparam logic [CNT_W-1:0] PIN_ONE = CNT_W'(1);

	typedef struct packed {
		status_t             status;
		logic [POS_W-1:0]    pos;
		logic [CNT_W-1:0]    pins;
		logic [PAGE_W-1:0]   evicted;
		logic                wb;
	} pool_result_t;

	// Shadow copy of the page queue, head at index 0
	logic [PAGE_W-1:0]   slot_page  [MAX_FRAMES];
	logic [CNT_W-1:0]    slot_pins  [MAX_FRAMES];
	logic                slot_dirty [MAX_FRAMES];
	int                  resident;
	logic [FRAMES_W-1:0] frame_cap;

	pool_result_t        pool_results_q[$];
	pool_result_t        predicted, observed, oldest;
	int                  status_seen [0:5];

	initial begin
		fail_count = 0;
		pending    = 0;
		for (int s = 0; s < 6; s++) status_seen[s] = 0;
	end

	// Applies one request to the shadow pool and returns the result it must produce
	task automatic apply_request(input logic op, input logic [PAGE_W-1:0] page,
	                             input logic dirty, output pool_result_t r);
		int found;
		int lim;
		int victim;
		r = '0;
		found = resident;
		for (int i = resident - 1; i >= 0; i--)
			if (slot_page[i] == page) found = i;
		lim = (frame_cap == 0) ? 1 : ((frame_cap > MAX_FRAMES) ? MAX_FRAMES : int'(frame_cap));

		if (op == OP_UNFIX) begin
			if (found == resident) begin
				r.status = ST_UNFIX_MISS;
			end else begin
				// count saturates at zero, dirty mark is taken regardless
				if (slot_pins[found] != 0) slot_pins[found] = slot_pins[found] - PIN_ONE;
				slot_dirty[found] = dirty;
				r.status = ST_UNFIXED;
				r.pos    = POS_W'(found);
				r.pins   = slot_pins[found];
			end
		end else if (found < resident) begin
			if (slot_pins[found] != PIN_MAX) slot_pins[found] = slot_pins[found] + PIN_ONE;
			r.status = ST_HIT;
			r.pos    = POS_W'(found);
			r.pins   = slot_pins[found];
		end else if (resident < lim) begin
			slot_page[resident]  = page;
			slot_pins[resident]  = PIN_ONE;
			slot_dirty[resident] = 1'b0;
			resident++;
			r.status = ST_LOADED;
			r.pos    = POS_W'(resident - 1);
			r.pins   = PIN_ONE;
		end else begin
			// full pool (or limit lowered below occupancy): oldest unpinned page goes
			victim = resident;
			for (int i = resident - 1; i >= 0; i--)
				if (slot_pins[i] == 0) victim = i;
			if (victim == resident) begin
				r.status = ST_FULL;
			end else begin
				r.evicted = slot_page[victim];
				r.wb      = slot_dirty[victim];
				for (int j = victim; j < resident - 1; j++) begin
					slot_page[j]  = slot_page[j+1];
					slot_pins[j]  = slot_pins[j+1];
					slot_dirty[j] = slot_dirty[j+1];
				end
				slot_page[resident-1]  = page;
				slot_pins[resident-1]  = PIN_ONE;
				slot_dirty[resident-1] = 1'b0;
				r.status = ST_EVICTED;
				r.pos    = POS_W'(resident - 1);
				r.pins   = PIN_ONE;
			end
		end
	endtask

	// Register snoop, request prediction and result comparison
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			resident  = 0;
			frame_cap = FRAMES_RESET;
			pool_results_q.delete();
			pending   = 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr[2] == REG_FRAMES)
				frame_cap = pwdata[FRAMES_W-1:0];

			if (in_valid && !in_stall) begin
				apply_request(operation, page_id, mark_dirty, predicted);
				pool_results_q = {pool_results_q, predicted};
			end

			if (out_valid && !out_stall) begin
				observed.status  = status_t'(status);
				observed.pos     = queue_position;
				observed.pins    = pin_count;
				observed.evicted = evicted_page_id;
				observed.wb      = write_back;
				if (pool_results_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("[%0t] unexpected transaction: status %0d pos %0d pins %0d",
							$time, status, queue_position, pin_count);
				end else begin
					oldest = pool_results_q.pop_front();
					status_seen[oldest.status]++;
					if (observed !== oldest) begin
						fail_count++;
						if (fail_count <= 10)
							$display({"[%0t] mismatch: expected status %0d pos %0d pins %0d ",
								"evicted %h wb %0d, got status %0d pos %0d pins %0d ",
								"evicted %h wb %0d"}, $time,
								oldest.status, oldest.pos, oldest.pins, oldest.evicted,
								oldest.wb, observed.status, observed.pos, observed.pins,
								observed.evicted, observed.wb);
					end
				end
			end
			pending = pool_results_q.size();
		end
	end

endmodule

@@ tb/fifo_buffer_pool_pinning_tb.sv @@
// Testbench top for the FIFO page buffer pool: stimulus, idling, register writes and verdict.
`timescale 1ns / 1ps

module fifo_buffer_pool_pinning_tb;
	import fbpp_pkg::*;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic                  operation = OP_FIX;
	logic [PAGE_W-1:0]     page_id = '0;
	logic                  mark_dirty = 1'b0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [STATUS_W-1:0]   status;
	logic [POS_W-1:0]      queue_position;
	logic [CNT_W-1:0]      pin_count;
	logic [PAGE_W-1:0]     evicted_page_id;
	logic                  write_back;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [APB_ADDR_W-1:0] paddr = '0;
	logic [APB_DATA_W-1:0] pwdata = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	int                    chk_fails;
	int                    chk_pending;
	logic                  calm = 1'b0;
	int                    requests_sent = 0;
	int                    limit_writes = 0;
	logic [PAGE_W-1:0]     page_set [24];

	fifo_buffer_pool_pinning uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .operation(operation),
		.page_id(page_id), .mark_dirty(mark_dirty),
		.out_valid(out_valid), .out_stall(out_stall), .status(status),
		.queue_position(queue_position), .pin_count(pin_count),
		.evicted_page_id(evicted_page_id), .write_back(write_back),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	fbpp_checker chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .operation(operation),
		.page_id(page_id), .mark_dirty(mark_dirty),
		.out_valid(out_valid), .out_stall(out_stall), .status(status),
		.queue_position(queue_position), .pin_count(pin_count),
		.evicted_page_id(evicted_page_id), .write_back(write_back),
		.psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
		.paddr(paddr), .pwdata(pwdata),
		.fail_count(chk_fails), .pending(chk_pending)
	);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Result side backpressure
	always @(posedge clk)
		out_stall <= !calm && ($urandom_range(0, 99) < 26);

	// Hard stop
	initial begin
		#8_000_000;
		$display("fifo_buffer_pool_pinning regression: fail");
		$finish;
	end

	// One request transaction, with an occasional gap ahead of it
	task automatic send_request(input logic op, input logic [PAGE_W-1:0] page,
	                            input logic dirty);
		if (!calm && $urandom_range(0, 99) < 26) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_valid   <= 1'b1;
		operation  <= op;
		page_id    <= page;
		mark_dirty <= dirty;
		do @(posedge clk); while (in_stall);
		requests_sent++;
	endtask

	// Wait until every predicted result has come back
	task automatic wait_idle(input int extra);
		int n;
		n = 0;
		in_valid <= 1'b0;
		do begin
			@(negedge clk);
			n++;
		end while (chk_pending != 0 && n < 4000);
		repeat (extra) @(posedge clk);
	endtask

	// Frame limit write over APB, only with the pool idle
	task automatic write_frames(input logic [FRAMES_W-1:0] value);
		wait_idle(4);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {REG_FRAMES, 2'b00};
		pwdata  <= APB_DATA_W'(value);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		limit_writes++;
	endtask

	// Random requests over a working set a little larger than the frame limit
	task automatic run_random(input int count, input logic [FRAMES_W-1:0] limit_val);
		int eff;
		int span;
		int fix_pct;
		logic [PAGE_W-1:0] pg;
		eff     = (limit_val == 0) ? 1 : ((limit_val > 16) ? 16 : int'(limit_val));
		span    = (eff + 6 > 24) ? 24 : eff + 6;
		fix_pct = $urandom_range(35, 60);
		for (int k = 0; k < count; k++) begin
			if ($urandom_range(0, 9) == 0)
				pg = {$urandom, $urandom};
			else
				pg = page_set[$urandom_range(0, span - 1)];
			send_request(($urandom_range(0, 99) < fix_pct) ? OP_FIX : OP_UNFIX, pg,
				1'($urandom_range(0, 1)));
		end
	endtask

	initial begin
		logic [FRAMES_W-1:0] limits [10];
		int calm_phase;
		page_set[0] = '0;
		page_set[1] = '1;
		for (int i = 2; i < 24; i++) page_set[i] = {$urandom, $urandom};
		limits = '{5'd16, 5'd1, 5'd4, 5'd31, 5'd0, 5'd8, 5'd16, 5'd2, 5'd12, 5'd0};
		limits[9] = 5'($urandom_range(0, 31));
		calm_phase = $urandom_range(0, 9);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: loads, hit, unfix down to zero and past it, unfix of absent page
		send_request(OP_FIX,   page_set[0], 1'b0);
		send_request(OP_FIX,   page_set[1], 1'b0);
		send_request(OP_FIX,   page_set[0], 1'b0);
		send_request(OP_UNFIX, page_set[0], 1'b1);
		send_request(OP_UNFIX, page_set[0], 1'b0);
		send_request(OP_UNFIX, page_set[0], 1'b1);
		send_request(OP_UNFIX, page_set[7], 1'b1);

		// Two frames: evict a dirty page, then every entry pinned
		write_frames(5'd2);
		send_request(OP_FIX, page_set[2], 1'b0);
		send_request(OP_FIX, page_set[3], 1'b0);

		// Zero acts as one frame, below occupancy: eviction keeps occupancy
		write_frames(5'd0);
		send_request(OP_UNFIX, page_set[2], 1'b0);
		send_request(OP_FIX,   page_set[3], 1'b0);

		// Above the maximum acts as sixteen frames
		write_frames(5'd31);
		send_request(OP_FIX, page_set[4], 1'b0);

		// Pin count saturation on a hot page
		for (int k = 0; k < 258; k++) send_request(OP_FIX, page_set[6], 1'b0);
		for (int k = 0; k < 3; k++) send_request(OP_UNFIX, page_set[6], 1'b1);

		// Random phases across frame limits
		for (int p = 0; p < 10; p++) begin
			write_frames(limits[p]);
			calm = (p == calm_phase);
			run_random(55, limits[p]);
		end
		calm = 1'b0;

		wait_idle(80);
		$display("covered %0d requests over %0d frame-limit writes", requests_sent,
			limit_writes);
		$display("results: hit %0d load %0d evict %0d full %0d unfix %0d unfix-miss %0d",
			chk.status_seen[ST_HIT], chk.status_seen[ST_LOADED],
			chk.status_seen[ST_EVICTED], chk.status_seen[ST_FULL],
			chk.status_seen[ST_UNFIXED], chk.status_seen[ST_UNFIX_MISS]);
		if (chk_fails == 0 && chk_pending == 0)
			$display("fifo_buffer_pool_pinning regression: pass");
		else
			$display("fifo_buffer_pool_pinning regression: fail");
		$finish;
	end

endmodule
